// ----- hw/rtl/c3s_pkg.sv -----
package c3s_pkg;

    // default build parameters
    localparam int DEF_MAX_PADDED_COLS = 1024;
    localparam int DEF_PIXEL_BITS      = 8;

    // fixed field widths
    localparam int CNT_W    = 10;
    localparam int OUT_W    = 20;
    localparam int WGT_W    = 8;
    localparam int WROW_W   = 24;
    localparam int TAPS     = 9;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // largest interior row or column count
    localparam logic [CNT_W-1:0] COUNT_LIMIT = 10'd1022;

    // reset values of the register file
    localparam logic [CNT_W-1:0]  RST_WIDTH   = 10'd512;
    localparam logic [CNT_W-1:0]  RST_HEIGHT  = 10'd512;
    localparam logic [WROW_W-1:0] RST_WTOP    = 24'h000000;
    localparam logic [WROW_W-1:0] RST_WMID    = 24'h000100;
    localparam logic [WROW_W-1:0] RST_WBOTTOM = 24'h000000;

    // register map, word index
    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH    = 3'd0,
        REG_IMAGE_HEIGHT   = 3'd1,
        REG_WEIGHTS_TOP    = 3'd2,
        REG_WEIGHTS_MID    = 3'd3,
        REG_WEIGHTS_BOTTOM = 3'd4
    } reg_idx_t;

endpackage

// ----- hw/rtl/c3s_fifo.sv -----
module c3s_fifo
    import c3s_pkg::*;
#(
    parameter int DW = 73
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  logic [DW-1:0]         push_data,
    input  logic                  pop,
    output logic                  fifo_valid,
    output logic [DW-1:0]         fifo_data,
    output logic [FIFO_CNT_W-1:0] fifo_count
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    logic [DW-1:0]         entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg;
    logic [PTR_W-1:0]      rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;

    // occupancy
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign fifo_valid = (count_reg != '0);
    assign fifo_data  = entry_reg[rd_ptr_reg];
    assign fifo_count = count_reg;

endmodule

// ----- hw/rtl/c3s_front.sv -----
module c3s_front
    import c3s_pkg::*;
#(
    parameter int MAX_PADDED_COLS = DEF_MAX_PADDED_COLS,
    parameter int PIXEL_BITS      = DEF_PIXEL_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [PIXEL_BITS-1:0]       s_pixel,
    input  logic [CNT_W-1:0]            image_width,
    input  logic [CNT_W-1:0]            image_height,
    input  logic [FIFO_CNT_W-1:0]       fifo_count,
    output logic                        push,
    output logic [TAPS*PIXEL_BITS:0]    push_data
);

    localparam int IDX_W = (MAX_PADDED_COLS > 2) ? $clog2(MAX_PADDED_COLS) : 1;
    localparam int WLIM_I = (MAX_PADDED_COLS - 2 < 1022) ? MAX_PADDED_COLS - 2 : 1022;
    localparam logic [CNT_W-1:0] WLIM = CNT_W'(WLIM_I);

    logic [PIXEL_BITS-1:0] line_a_mem [MAX_PADDED_COLS];
    logic [PIXEL_BITS-1:0] line_b_mem [MAX_PADDED_COLS];

    logic [CNT_W-1:0]      col_reg;
    logic [CNT_W-1:0]      row_reg;
    logic [CNT_W-1:0]      w_lim;
    logic [CNT_W-1:0]      h_lim;
    logic                  row_end;
    logic                  frame_end;
    logic                  emit;
    logic                  accept;
    logic [IDX_W-1:0]      rd_idx;

    logic                  vb_reg;
    logic                  emit_b_reg;
    logic                  last_b_reg;
    logic [IDX_W-1:0]      addr_b_reg;
    logic [PIXEL_BITS-1:0] pix_b_reg;
    logic [PIXEL_BITS-1:0] top_rd_reg;
    logic [PIXEL_BITS-1:0] mid_rd_reg;
    logic [PIXEL_BITS-1:0] win_reg [6];

    // clamp frame size and classify the incoming word
    always_comb begin
        w_lim     = (image_width > WLIM) ? WLIM : image_width;
        h_lim     = (image_height > COUNT_LIMIT) ? COUNT_LIMIT : image_height;
        row_end   = ({1'b0, col_reg} >= ({1'b0, w_lim} + 1'b1));
        frame_end = row_end && ({1'b0, row_reg} >= ({1'b0, h_lim} + 1'b1));
        emit      = (row_reg >= CNT_W'(2)) && (col_reg >= CNT_W'(2));
        rd_idx    = IDX_W'(col_reg);
    end

    // take a word only if the queue has room for everything in flight
    assign push    = vb_reg && emit_b_reg;
    assign s_ready = ({1'b0, fifo_count} + (FIFO_CNT_W + 1)'(push))
                     < (FIFO_CNT_W + 1)'(FIFO_DEPTH);
    assign accept  = s_valid && s_ready;

    // column and row counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            if (row_end) begin
                col_reg <= '0;
                row_reg <= frame_end ? '0 : row_reg + 1'b1;
            end else begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // line buffer read, registered in step with the window stage
    always_ff @(posedge aclk) begin
        top_rd_reg <= line_b_mem[rd_idx];
        mid_rd_reg <= line_a_mem[rd_idx];
    end

    // line buffer write from the window stage
    always_ff @(posedge aclk) begin
        if (vb_reg) begin
            line_b_mem[addr_b_reg] <= mid_rd_reg;
            line_a_mem[addr_b_reg] <= pix_b_reg;
        end
    end

    // window stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else begin
            vb_reg <= accept;
        end
    end

    // window stage payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            emit_b_reg <= emit;
            last_b_reg <= frame_end;
            addr_b_reg <= rd_idx;
            pix_b_reg  <= s_pixel;
        end
    end

    // 3x3 window shift
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (vb_reg) begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= top_rd_reg;
            win_reg[2] <= win_reg[3];
            win_reg[3] <= mid_rd_reg;
            win_reg[4] <= win_reg[5];
            win_reg[5] <= pix_b_reg;
        end
    end

    // neighborhood word, tap 0 (top left) in the low bits
    assign push_data = {last_b_reg, pix_b_reg, win_reg[5], win_reg[4], mid_rd_reg,
                        win_reg[3], win_reg[2], top_rd_reg, win_reg[1], win_reg[0]};

endmodule

// ----- hw/rtl/c3s_back.sv -----
module c3s_back
    import c3s_pkg::*;
#(
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      fifo_valid,
    input  logic [TAPS*PIXEL_BITS:0]  fifo_data,
    output logic                      pop,
    input  logic [WROW_W-1:0]         weights_top,
    input  logic [WROW_W-1:0]         weights_mid,
    input  logic [WROW_W-1:0]         weights_bottom,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [OUT_W-1:0]   m_filtered_value,
    output logic                      m_last_of_frame
);

    localparam int EXT_W = (PIXEL_BITS + 9 > OUT_W) ? PIXEL_BITS + 9 : OUT_W;

    logic [2:0][WROW_W-1:0] wrows;
    logic [OUT_W-1:0]       prod [TAPS];

    logic                   v1_reg;
    logic                   v2_reg;
    logic                   out_valid_reg;
    logic                   ready1;
    logic                   ready2;
    logic                   ready3;
    logic [OUT_W-1:0]       prod_reg [TAPS];
    logic                   last1_reg;
    logic [OUT_W-1:0]       row_sum_reg [3];
    logic                   last2_reg;
    logic [OUT_W-1:0]       out_value_reg;
    logic                   out_last_reg;

    assign wrows = {weights_bottom, weights_mid, weights_top};

    // nine signed-by-unsigned products, wrapped to the output width
    for (genvar k = 0; k < TAPS; k++) begin : g_tap
        logic [EXT_W-1:0] full;
        assign full = EXT_W'(signed'(wrows[k / 3][(k % 3) * WGT_W +: WGT_W]))
                    * EXT_W'(fifo_data[k * PIXEL_BITS +: PIXEL_BITS]);
        assign prod[k] = full[OUT_W-1:0];
    end

    // stage handshake, each stage moves when the next one frees up
    assign ready3 = !out_valid_reg || m_ready;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;
    assign pop    = fifo_valid && ready1;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (ready1) begin
                v1_reg <= fifo_valid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
            if (ready3) begin
                out_valid_reg <= v2_reg;
            end
        end
    end

    // multiply stage
    always_ff @(posedge aclk) begin
        if (ready1) begin
            for (int k = 0; k < TAPS; k++) begin
                prod_reg[k] <= prod[k];
            end
            last1_reg <= fifo_data[TAPS*PIXEL_BITS];
        end
    end

    // row sums
    always_ff @(posedge aclk) begin
        if (ready2) begin
            for (int r = 0; r < 3; r++) begin
                row_sum_reg[r] <= prod_reg[3*r] + prod_reg[3*r+1] + prod_reg[3*r+2];
            end
            last2_reg <= last1_reg;
        end
    end

    // final sum into the output register
    always_ff @(posedge aclk) begin
        if (ready3) begin
            out_value_reg <= row_sum_reg[0] + row_sum_reg[1] + row_sum_reg[2];
            out_last_reg  <= last2_reg;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_filtered_value = signed'(out_value_reg);
    assign m_last_of_frame  = out_last_reg;

endmodule

// ----- hw/rtl/conv3x3_stencil_unit.sv -----
// 3x3 convolution over a zero-bordered image streamed one pixel per word in row-major
// order, border included. The unit takes one pixel every cycle while s_ready is high
// and, for each interior pixel, returns the weighted sum of its 3x3 neighborhood once
// the bottom-right neighbor has arrived; the last interior result of a frame carries
// last_of_frame. Two line buffer memories (one read and one write per cycle) and a
// counter pair feed a four-word queue; a three-stage multiply and adder pipeline
// drains it; a result passes window stage, queue and pipeline before m_valid rises.
// Input stalls only when the queue, counting the word in the window stage, is full.
// Line buffers are not cleared: each frame fills them before use.
// Registers (APB, 4-byte stride): image_width, image_height, weights_top, weights_mid,
// weights_bottom; weights are signed bytes left [7:0], middle [15:8], right [23:16].
// Write registers only while the unit is idle.
module conv3x3_stencil_unit
    import c3s_pkg::*;
#(
    parameter int MAX_PADDED_COLS = DEF_MAX_PADDED_COLS,
    parameter int PIXEL_BITS      = DEF_PIXEL_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [4:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [PIXEL_BITS-1:0]     s_pixel,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [OUT_W-1:0]   m_filtered_value,
    output logic                      m_last_of_frame
);

    localparam int DW = TAPS * PIXEL_BITS + 1;

    logic [CNT_W-1:0]      width_reg;
    logic [CNT_W-1:0]      height_reg;
    logic [WROW_W-1:0]     wtop_reg;
    logic [WROW_W-1:0]     wmid_reg;
    logic [WROW_W-1:0]     wbot_reg;
    logic                  wr_en;
    reg_idx_t              reg_idx;

    logic                  push;
    logic [DW-1:0]         push_data;
    logic                  pop;
    logic                  fifo_valid;
    logic [DW-1:0]         fifo_data;
    logic [FIFO_CNT_W-1:0] fifo_count;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[4:2]);

    // register file writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            wtop_reg   <= RST_WTOP;
            wmid_reg   <= RST_WMID;
            wbot_reg   <= RST_WBOTTOM;
        end else if (wr_en) begin
            case (reg_idx)
                REG_IMAGE_WIDTH:    width_reg  <= pwdata[CNT_W-1:0];
                REG_IMAGE_HEIGHT:   height_reg <= pwdata[CNT_W-1:0];
                REG_WEIGHTS_TOP:    wtop_reg   <= pwdata[WROW_W-1:0];
                REG_WEIGHTS_MID:    wmid_reg   <= pwdata[WROW_W-1:0];
                REG_WEIGHTS_BOTTOM: wbot_reg   <= pwdata[WROW_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_idx)
            REG_IMAGE_WIDTH:    prdata = 32'(width_reg);
            REG_IMAGE_HEIGHT:   prdata = 32'(height_reg);
            REG_WEIGHTS_TOP:    prdata = 32'(wtop_reg);
            REG_WEIGHTS_MID:    prdata = 32'(wmid_reg);
            REG_WEIGHTS_BOTTOM: prdata = 32'(wbot_reg);
            default:            prdata = '0;
        endcase
    end

    // counters, line buffers and window
    c3s_front #(
        .MAX_PADDED_COLS (MAX_PADDED_COLS),
        .PIXEL_BITS      (PIXEL_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel      (s_pixel),
        .image_width  (width_reg),
        .image_height (height_reg),
        .fifo_count   (fifo_count),
        .push         (push),
        .push_data    (push_data)
    );

    // neighborhood queue
    c3s_fifo #(
        .DW (DW)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .fifo_valid (fifo_valid),
        .fifo_data  (fifo_data),
        .fifo_count (fifo_count)
    );

    // multiply-accumulate and output register
    c3s_back #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .fifo_valid       (fifo_valid),
        .fifo_data        (fifo_data),
        .pop              (pop),
        .weights_top      (wtop_reg),
        .weights_mid      (wmid_reg),
        .weights_bottom   (wbot_reg),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_filtered_value (m_filtered_value),
        .m_last_of_frame  (m_last_of_frame)
    );

endmodule
